>>> rtl/core/dec_pkg.sv
// ----------------------------------------------------------------------------
// dec_pkg - shared types and constants for the disc collision block
// Item and result layouts, outcome codes and queue sizing.
// ----------------------------------------------------------------------------
package dec_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH       = 4;
    localparam int RADIUS_W          = 10;

    typedef enum logic [1:0] {
        OUTCOME_PASS   = 2'd0,
        OUTCOME_BOUNCE = 2'd1,
        OUTCOME_PUSH   = 2'd2
    } outcome_t;

    typedef struct packed {
        logic signed [31:0]   a_pos_x;
        logic signed [31:0]   a_pos_y;
        logic signed [31:0]   a_vel_x;
        logic signed [31:0]   a_vel_y;
        logic [RADIUS_W-1:0]  a_radius;
        logic [31:0]          a_mass;
        logic signed [31:0]   b_pos_x;
        logic signed [31:0]   b_pos_y;
        logic signed [31:0]   b_vel_x;
        logic signed [31:0]   b_vel_y;
        logic [RADIUS_W-1:0]  b_radius;
        logic [31:0]          b_mass;
    } disc_pair_t;

    typedef struct packed {
        logic signed [31:0] new_a_pos_x;
        logic signed [31:0] new_a_pos_y;
        logic signed [31:0] new_a_vel_x;
        logic signed [31:0] new_a_vel_y;
        logic signed [31:0] new_b_pos_x;
        logic signed [31:0] new_b_pos_y;
        logic signed [31:0] new_b_vel_x;
        logic signed [31:0] new_b_vel_y;
        outcome_t           outcome;
        logic               saturated;
    } disc_result_t;

    typedef struct packed {
        disc_pair_t item;
        outcome_t   cls;
    } dec_entry_t;

endpackage

>>> rtl/core/disc_elastic_collision.sv
// ----------------------------------------------------------------------------
// disc_elastic_collision - elastic collision response for disc pairs
// Classifying front, short queue and pipelined response back end.
// ----------------------------------------------------------------------------
// Takes one disc pair per clock while s_ready is high and returns one result per
// pair, in order. Values are Q16.16 at the default FRAC_BITS. A pair passes
// through two front stages, the queue, a mass-sum stage, a FRAC_BITS+2 stage
// mass-ratio divider, five dot-product and multiply stages, a 33 stage impulse
// divider, one scaling stage and the output register; the back end holds while
// a result is stalled. The queue holds four pairs, so the input side keeps
// accepting while a result waits, until four pairs fill the front stages and queue.

module disc_elastic_collision #(
    parameter int FRAC_BITS = dec_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dec_pkg::disc_pair_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dec_pkg::disc_result_t m_data
);

    logic                q_wr_valid;
    dec_pkg::dec_entry_t q_wr_data;
    logic                q_rd_valid;
    dec_pkg::dec_entry_t q_rd_data;
    logic                q_pop;

    dec_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk       (aclk),
        .rstn      (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_wr_valid(q_wr_valid),
        .q_wr_data (q_wr_data),
        .q_pop     (q_pop)
    );

    dec_queue u_queue (
        .clk     (aclk),
        .rstn    (aresetn),
        .wr_valid(q_wr_valid),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_valid(q_rd_valid),
        .rd_data (q_rd_data)
    );

    dec_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk    (aclk),
        .rstn   (aresetn),
        .q_valid(q_rd_valid),
        .q_data (q_rd_data),
        .q_pop  (q_pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

endmodule

>>> rtl/core/dec_div.sv
// ----------------------------------------------------------------------------
// dec_div - pipelined restoring divider
// One quotient bit per stage; the quotient must be known to fit QW bits.
// ----------------------------------------------------------------------------
module dec_div #(
    parameter int NW = 49,
    parameter int DW = 33,
    parameter int QW = 18,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rstn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_out
);

    localparam int HW = NW - QW;

    logic          v_reg    [QW];
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] low_reg  [QW];
    logic [QW-1:0] q_reg    [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          v_in;
        logic [DW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] q_in;
        logic [DW-1:0] den_in;
        logic [SW-1:0] side_w;
        logic [DW:0]   trial;
        logic          fit;

        if (k == 0) begin : g_first
            logic [HW-1:0] hi;
            assign hi     = num[NW-1:QW];
            assign v_in   = in_valid;
            assign rem_in = DW'(hi);
            assign low_in = num[QW-1:0];
            assign q_in   = '0;
            assign den_in = den;
            assign side_w = side_in;
        end else begin : g_next
            assign v_in   = v_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign den_in = den_reg[k-1];
            assign side_w = side_reg[k-1];
        end

        assign trial = {rem_in, low_in[QW-1-k]};
        assign fit   = trial >= {1'b0, den_in};

        always_ff @(posedge clk) begin
            if (!rstn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[k]  <= fit ? DW'(trial - {1'b0, den_in}) : DW'(trial);
                low_reg[k]  <= low_in;
                q_reg[k]    <= {q_in[QW-2:0], fit};
                den_reg[k]  <= den_in;
                side_reg[k] <= side_w;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quo       = q_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

>>> rtl/core/dec_queue.sv
// ----------------------------------------------------------------------------
// dec_queue - classified item queue between front and back
// Space is reserved by the front's credit count, so writes never overflow.
// ----------------------------------------------------------------------------
module dec_queue (
    input  logic                clk,
    input  logic                rstn,
    input  logic                wr_valid,
    input  dec_pkg::dec_entry_t wr_data,
    input  logic                pop,
    output logic                rd_valid,
    output dec_pkg::dec_entry_t rd_data
);

    localparam int AW = $clog2(dec_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(dec_pkg::QUEUE_DEPTH + 1);

    dec_pkg::dec_entry_t entry_reg [dec_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb begin
        wptr_next  = wr_valid ? wptr_reg + AW'(1) : wptr_reg;
        rptr_next  = pop ? rptr_reg + AW'(1) : rptr_reg;
        count_next = count_reg + CW'(wr_valid) - CW'(pop);
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (wr_valid) begin
            entry_reg[wptr_reg] <= wr_data;
        end
    end

    assign rd_valid = count_reg != '0;
    assign rd_data  = entry_reg[rptr_reg];

endmodule

>>> rtl/core/dec_front.sv
// ----------------------------------------------------------------------------
// dec_front - overlap classification
// Squares the centre distance and the radius sum and sorts each pair into
// pass-through, bounce or coincident push.
// ----------------------------------------------------------------------------
module dec_front #(
    parameter int FRAC_BITS = dec_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rstn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dec_pkg::disc_pair_t  s_data,
    output logic                 q_wr_valid,
    output dec_pkg::dec_entry_t  q_wr_data,
    input  logic                 q_pop
);

    localparam int CW   = $clog2(dec_pkg::QUEUE_DEPTH + 1);
    localparam int RSW  = dec_pkg::RADIUS_W + 1;
    localparam int DXW  = RSW + FRAC_BITS;
    localparam int R2W  = 2 * DXW;
    localparam int CMPW = (R2W > 67) ? R2W : 67;

    logic [CW-1:0] credit_reg, credit_next;
    logic          acc;

    logic                v1_reg;
    dec_pkg::disc_pair_t item1_reg;
    logic [32:0]         dxm1_reg, dym1_reg;
    logic [RSW-1:0]      rs1_reg;

    logic                v2_reg;
    dec_pkg::disc_pair_t item2_reg;
    logic [65:0]         sqx2_reg, sqy2_reg;
    logic [R2W-1:0]      r2_2_reg;

    logic [32:0]    dx, dy, dxm, dym;
    logic [DXW-1:0] rsh;
    logic [66:0]    d2;
    logic           overlap;
    dec_pkg::outcome_t cls;

    // credit covers the two stages in flight and the queue itself
    assign acc     = s_valid && s_ready;
    assign s_ready = credit_reg < CW'(dec_pkg::QUEUE_DEPTH);

    always_comb begin
        credit_next = credit_reg + CW'(acc) - CW'(q_pop);
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            credit_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
        end else begin
            credit_reg <= credit_next;
            v1_reg     <= acc;
            v2_reg     <= v1_reg;
        end
    end

    always_comb begin
        dx  = {s_data.a_pos_x[31], s_data.a_pos_x} - {s_data.b_pos_x[31], s_data.b_pos_x};
        dy  = {s_data.a_pos_y[31], s_data.a_pos_y} - {s_data.b_pos_y[31], s_data.b_pos_y};
        dxm = dx[32] ? 33'(-dx) : dx;
        dym = dy[32] ? 33'(-dy) : dy;
        rsh = {rs1_reg, {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge clk) begin
        item1_reg <= s_data;
        dxm1_reg  <= dxm;
        dym1_reg  <= dym;
        rs1_reg   <= {1'b0, s_data.a_radius} + {1'b0, s_data.b_radius};
        item2_reg <= item1_reg;
        sqx2_reg  <= 66'(dxm1_reg) * 66'(dxm1_reg);
        sqy2_reg  <= 66'(dym1_reg) * 66'(dym1_reg);
        r2_2_reg  <= R2W'(rsh) * R2W'(rsh);
    end

    always_comb begin
        d2      = {1'b0, sqx2_reg} + {1'b0, sqy2_reg};
        overlap = CMPW'(d2) < CMPW'(r2_2_reg);
        if (!overlap) begin
            cls = dec_pkg::OUTCOME_PASS;
        end else if (d2 == '0) begin
            cls = dec_pkg::OUTCOME_PUSH;
        end else begin
            cls = dec_pkg::OUTCOME_BOUNCE;
        end
    end

    assign q_wr_valid     = v2_reg;
    assign q_wr_data.item = item2_reg;
    assign q_wr_data.cls  = cls;

endmodule

>>> rtl/core/dec_back.sv
// ----------------------------------------------------------------------------
// dec_back - collision response datapath
// Mass ratios, dot product, per-axis impulse division and saturating update.
// The whole pipe advances together whenever the output register can move.
// ----------------------------------------------------------------------------
module dec_back #(
    parameter int FRAC_BITS = dec_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rstn,
    input  logic                  q_valid,
    input  dec_pkg::dec_entry_t   q_data,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dec_pkg::disc_result_t m_data
);

    localparam int F    = FRAC_BITS;
    localparam int MW   = 33;
    localparam int RW   = F + 2;
    localparam int RNW  = 33 + F;
    localparam int DXW  = dec_pkg::RADIUS_W + 1 + F;
    localparam int PW   = MW + DXW;
    localparam int DOTW = PW + 1;
    localparam int D2W  = 2 * DXW;
    localparam int NUMW = DOTW + DXW;
    localparam int HIW  = DOTW - 32;
    localparam int TW   = 33;
    localparam int PRW  = RW + TW;
    localparam int SHW  = PRW - F;
    localparam int VW   = SHW + 3;
    localparam int EW   = $bits(dec_pkg::dec_entry_t);

    typedef struct packed {
        dec_pkg::dec_entry_t e;
        logic [RW-1:0]       ra;
        logic [RW-1:0]       rb;
    } ctx_t;

    typedef struct packed {
        ctx_t c;
        logic tneg;
    } xside_t;

    localparam int XSW = $bits(xside_t);

    function automatic logic [VW-1:0] sx(input logic [31:0] x);
        return {{(VW-32){x[31]}}, x};
    endfunction

    function automatic logic [32:0] sat32(input logic [VW-1:0] v);
        logic [32:0] r;
        if ((&v[VW-1:31]) || !(|v[VW-1:31])) begin
            r = {1'b0, v[31:0]};
        end else if (v[VW-1]) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b1, 32'h7fff_ffff};
        end
        return r;
    endfunction

    logic adv;
    logic m_valid_reg;
    dec_pkg::disc_result_t m_data_reg, res;

    assign adv   = !m_valid_reg || m_ready;
    assign q_pop = adv && q_valid;

    // ---- mass sum
    logic                v0_reg;
    dec_pkg::dec_entry_t e0_reg;
    logic [MW-1:0]       msum0_reg;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= q_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            e0_reg    <= q_data;
            msum0_reg <= {1'b0, q_data.item.a_mass} + {1'b0, q_data.item.b_mass};
        end
    end

    // ---- mass ratios
    logic                vr;
    logic [RW-1:0]       ra_q, rb_q;
    logic [EW-1:0]       er_vec;
    logic [0:0]          mz;
    dec_pkg::dec_entry_t er;

    dec_div #(.NW(RNW), .DW(MW), .QW(RW), .SW(EW)) u_div_ra (
        .clk      (clk),
        .rstn     (rstn),
        .en       (adv),
        .in_valid (v0_reg),
        .num      ({e0_reg.item.a_mass, {(F+1){1'b0}}}),
        .den      (msum0_reg),
        .side_in  (e0_reg),
        .out_valid(vr),
        .quo      (ra_q),
        .side_out (er_vec)
    );

    dec_div #(.NW(RNW), .DW(MW), .QW(RW), .SW(1)) u_div_rb (
        .clk      (clk),
        .rstn     (rstn),
        .en       (adv),
        .in_valid (v0_reg),
        .num      ({e0_reg.item.b_mass, {(F+1){1'b0}}}),
        .den      (msum0_reg),
        .side_in  (msum0_reg == '0),
        .out_valid(),
        .quo      (rb_q),
        .side_out (mz)
    );

    assign er = er_vec;

    // ---- differences
    logic [32:0] dx, dy, dvx, dvy, dxm, dym, dvxm, dvym;
    ctx_t        c1;

    always_comb begin
        dx   = {er.item.a_pos_x[31], er.item.a_pos_x} - {er.item.b_pos_x[31], er.item.b_pos_x};
        dy   = {er.item.a_pos_y[31], er.item.a_pos_y} - {er.item.b_pos_y[31], er.item.b_pos_y};
        dvx  = {er.item.a_vel_x[31], er.item.a_vel_x} - {er.item.b_vel_x[31], er.item.b_vel_x};
        dvy  = {er.item.a_vel_y[31], er.item.a_vel_y} - {er.item.b_vel_y[31], er.item.b_vel_y};
        dxm  = dx[32] ? 33'(-dx) : dx;
        dym  = dy[32] ? 33'(-dy) : dy;
        dvxm = dvx[32] ? 33'(-dvx) : dvx;
        dvym = dvy[32] ? 33'(-dvy) : dvy;
        c1.e  = er;
        c1.ra = mz[0] ? '0 : ra_q;
        c1.rb = mz[0] ? '0 : rb_q;
    end

    logic           v1_reg;
    ctx_t           c1_reg;
    logic [DXW-1:0] dxm1_reg, dym1_reg;
    logic [MW-1:0]  dvxm1_reg, dvym1_reg;
    logic           dxn1_reg, dyn1_reg, dvxn1_reg, dvyn1_reg;

    // ---- products
    logic           v2_reg;
    ctx_t           c2_reg;
    logic [PW-1:0]  p1_2_reg, p2_2_reg;
    logic [D2W-1:0] sqx2_reg, sqy2_reg;
    logic           n1_2_reg, n2_2_reg, dxn2_reg, dyn2_reg;
    logic [DXW-1:0] dxm2_reg, dym2_reg;

    // ---- dot product
    logic [DOTW-1:0] dot;
    logic            dneg;
    logic            v3_reg;
    ctx_t            c3_reg;
    logic [DOTW-1:0] dot3_reg;
    logic [D2W-1:0]  d2_3_reg;
    logic            tnx3_reg, tny3_reg;
    logic [DXW-1:0]  dxm3_reg, dym3_reg;

    // ---- split numerator products
    logic                v4_reg;
    ctx_t                c4_reg;
    logic [32+DXW-1:0]   lox4_reg, loy4_reg;
    logic [HIW+DXW-1:0]  hix4_reg, hiy4_reg;
    logic [D2W-1:0]      d2_4_reg;
    logic                tnx4_reg, tny4_reg;

    // ---- numerators
    logic            v5_reg;
    ctx_t            c5_reg;
    logic [NUMW-1:0] numx5_reg, numy5_reg;
    logic [D2W-1:0]  d2_5_reg;
    logic            tnx5_reg, tny5_reg;

    always_comb begin
        if (n1_2_reg == n2_2_reg) begin
            dot  = DOTW'(p1_2_reg) + DOTW'(p2_2_reg);
            dneg = n1_2_reg;
        end else if (p1_2_reg >= p2_2_reg) begin
            dot  = DOTW'(p1_2_reg - p2_2_reg);
            dneg = n1_2_reg;
        end else begin
            dot  = DOTW'(p2_2_reg - p1_2_reg);
            dneg = n2_2_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= vr;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            c1_reg    <= c1;
            dxm1_reg  <= DXW'(dxm);
            dym1_reg  <= DXW'(dym);
            dvxm1_reg <= dvxm;
            dvym1_reg <= dvym;
            dxn1_reg  <= dx[32];
            dyn1_reg  <= dy[32];
            dvxn1_reg <= dvx[32];
            dvyn1_reg <= dvy[32];

            c2_reg   <= c1_reg;
            p1_2_reg <= PW'(dvxm1_reg) * PW'(dxm1_reg);
            p2_2_reg <= PW'(dvym1_reg) * PW'(dym1_reg);
            sqx2_reg <= D2W'(dxm1_reg) * D2W'(dxm1_reg);
            sqy2_reg <= D2W'(dym1_reg) * D2W'(dym1_reg);
            n1_2_reg <= dvxn1_reg ^ dxn1_reg;
            n2_2_reg <= dvyn1_reg ^ dyn1_reg;
            dxn2_reg <= dxn1_reg;
            dyn2_reg <= dyn1_reg;
            dxm2_reg <= dxm1_reg;
            dym2_reg <= dym1_reg;

            c3_reg   <= c2_reg;
            dot3_reg <= dot;
            d2_3_reg <= D2W'(sqx2_reg + sqy2_reg);
            tnx3_reg <= dneg ^ dxn2_reg;
            tny3_reg <= dneg ^ dyn2_reg;
            dxm3_reg <= dxm2_reg;
            dym3_reg <= dym2_reg;

            c4_reg   <= c3_reg;
            lox4_reg <= (32+DXW)'(dot3_reg[31:0]) * (32+DXW)'(dxm3_reg);
            loy4_reg <= (32+DXW)'(dot3_reg[31:0]) * (32+DXW)'(dym3_reg);
            hix4_reg <= (HIW+DXW)'(dot3_reg[DOTW-1:32]) * (HIW+DXW)'(dxm3_reg);
            hiy4_reg <= (HIW+DXW)'(dot3_reg[DOTW-1:32]) * (HIW+DXW)'(dym3_reg);
            d2_4_reg <= d2_3_reg;
            tnx4_reg <= tnx3_reg;
            tny4_reg <= tny3_reg;

            c5_reg    <= c4_reg;
            numx5_reg <= (NUMW'(hix4_reg) << 32) + NUMW'(lox4_reg);
            numy5_reg <= (NUMW'(hiy4_reg) << 32) + NUMW'(loy4_reg);
            d2_5_reg  <= d2_4_reg;
            tnx5_reg  <= tnx4_reg;
            tny5_reg  <= tny4_reg;
        end
    end

    // ---- impulse per axis: t = dot * d / d2
    xside_t          xs_in, xs;
    logic [XSW-1:0]  xs_vec;
    logic            vt;
    logic [TW-1:0]   tx, ty;
    logic [0:0]      tny_o;

    assign xs_in.c    = c5_reg;
    assign xs_in.tneg = tnx5_reg;

    dec_div #(.NW(NUMW), .DW(D2W), .QW(TW), .SW(XSW)) u_div_tx (
        .clk      (clk),
        .rstn     (rstn),
        .en       (adv),
        .in_valid (v5_reg),
        .num      (numx5_reg),
        .den      (d2_5_reg),
        .side_in  (xs_in),
        .out_valid(vt),
        .quo      (tx),
        .side_out (xs_vec)
    );

    dec_div #(.NW(NUMW), .DW(D2W), .QW(TW), .SW(1)) u_div_ty (
        .clk      (clk),
        .rstn     (rstn),
        .en       (adv),
        .in_valid (v5_reg),
        .num      (numy5_reg),
        .den      (d2_5_reg),
        .side_in  (tny5_reg),
        .out_valid(),
        .quo      (ty),
        .side_out (tny_o)
    );

    assign xs = xs_vec;

    // ---- scale by mass ratios
    logic           v6_reg;
    ctx_t           c6_reg;
    logic           tnx6_reg, tny6_reg;
    logic [SHW-1:0] dax6_reg, dbx6_reg, day6_reg, dby6_reg;
    logic [PRW-1:0] pax, pbx, pay, pby;

    always_comb begin
        pax = PRW'(xs.c.rb) * PRW'(tx);
        pbx = PRW'(xs.c.ra) * PRW'(tx);
        pay = PRW'(xs.c.rb) * PRW'(ty);
        pby = PRW'(xs.c.ra) * PRW'(ty);
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            v6_reg <= 1'b0;
        end else if (adv) begin
            v6_reg <= vt;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            c6_reg   <= xs.c;
            tnx6_reg <= xs.tneg;
            tny6_reg <= tny_o[0];
            dax6_reg <= pax[PRW-1:F];
            dbx6_reg <= pbx[PRW-1:F];
            day6_reg <= pay[PRW-1:F];
            dby6_reg <= pby[PRW-1:F];
        end
    end

    // ---- final update and clamp
    logic [VW-1:0]  val [8];
    logic [32:0]    cl  [8];
    logic [DXW-2:0] h;
    logic [VW-1:0]  he, dax, dbx, day, dby;
    logic           sat;
    dec_pkg::disc_pair_t it;

    always_comb begin
        it  = c6_reg.e.item;
        h   = {({1'b0, it.a_radius} + {1'b0, it.b_radius}), {(F-1){1'b0}}};
        he  = VW'(h);
        dax = VW'(dax6_reg);
        dbx = VW'(dbx6_reg);
        day = VW'(day6_reg);
        dby = VW'(dby6_reg);
        val[0] = sx(it.a_pos_x);
        val[1] = sx(it.a_pos_y);
        val[2] = sx(it.a_vel_x);
        val[3] = sx(it.a_vel_y);
        val[4] = sx(it.b_pos_x);
        val[5] = sx(it.b_pos_y);
        val[6] = sx(it.b_vel_x);
        val[7] = sx(it.b_vel_y);
        case (c6_reg.e.cls)
            dec_pkg::OUTCOME_BOUNCE: begin
                val[2] = tnx6_reg ? sx(it.a_vel_x) + dax : sx(it.a_vel_x) - dax;
                val[3] = tny6_reg ? sx(it.a_vel_y) + day : sx(it.a_vel_y) - day;
                val[6] = tnx6_reg ? sx(it.b_vel_x) - dbx : sx(it.b_vel_x) + dbx;
                val[7] = tny6_reg ? sx(it.b_vel_y) - dby : sx(it.b_vel_y) + dby;
            end
            dec_pkg::OUTCOME_PUSH: begin
                // A moves towards negative x and y, B the other way
                val[0] = sx(it.a_pos_x) - he;
                val[1] = sx(it.a_pos_y) - he;
                val[4] = sx(it.b_pos_x) + he;
                val[5] = sx(it.b_pos_y) + he;
            end
            default: begin
            end
        endcase
        sat = 1'b0;
        for (int i = 0; i < 8; i++) begin
            cl[i] = sat32(val[i]);
            sat   = sat | cl[i][32];
        end
        res.new_a_pos_x = cl[0][31:0];
        res.new_a_pos_y = cl[1][31:0];
        res.new_a_vel_x = cl[2][31:0];
        res.new_a_vel_y = cl[3][31:0];
        res.new_b_pos_x = cl[4][31:0];
        res.new_b_pos_y = cl[5][31:0];
        res.new_b_vel_x = cl[6][31:0];
        res.new_b_vel_y = cl[7][31:0];
        res.outcome     = c6_reg.e.cls;
        res.saturated   = sat;
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/core/dec_checker.sv
// ----------------------------------------------------------------------------
// dec_checker - port-level checks for the disc collision block
// Result channel behaviour seen from outside the block.
// ----------------------------------------------------------------------------
module dec_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input dec_pkg::disc_result_t m_data
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // pass-through values are always in range
    a_pass_nosat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.outcome == dec_pkg::OUTCOME_PASS) |-> !m_data.saturated)
        else $error("pass-through item flagged as saturated");

    // nothing comes out straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // push moves the discs apart by the same amount on both axes when nothing clamps
    a_push_sym: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.outcome == dec_pkg::OUTCOME_PUSH) && !m_data.saturated
        |-> (m_data.new_b_pos_x - m_data.new_a_pos_x)
            == (m_data.new_b_pos_y - m_data.new_a_pos_y))
        else $error("push not applied evenly");

endmodule

bind disc_elastic_collision dec_checker u_dec_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

>>> tb/sv/disc_elastic_collision_test.sv
// ----------------------------------------------------------------------------
// disc_elastic_collision_test - self-checking bench for the disc collision block
// Drives disc pairs through the valid/ready input, predicts each response with
// a fixed-point collision model of its own and checks every result in order.
// ----------------------------------------------------------------------------
module disc_elastic_collision_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  F          = dec_pkg::FRAC_BITS_DEFAULT;
    localparam int  DRAIN_WAIT = F + 60;
    localparam longint CYCLE_LIMIT = 600000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    dec_pkg::disc_pair_t   s_data;
    logic                  m_valid;
    logic                  m_ready;
    dec_pkg::disc_result_t m_data;

    dec_pkg::disc_result_t expected_results[$];
    int           mismatches;
    longint       cycles;
    int           hold_cycles;
    int           ready_mode;

    disc_elastic_collision #(.FRAC_BITS(F)) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [31:0] sat32(input longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Collision response in exact wide arithmetic, truncating on magnitudes.
    function automatic dec_pkg::disc_result_t collide_pair(input dec_pkg::disc_pair_t p);
        longint apx, apy, avx, avy, bpx, bpy, bvx, bvy, h, da, db;
        longint dd[2];
        logic signed [127:0] dx, dy, dvx, dvy, dot;
        logic [127:0] d2, r2, adot, num, quo;
        logic [63:0]  rsum, msum, ra, rb, t, pa, pb;
        bit tneg, sat;
        dec_pkg::outcome_t oc;
        dec_pkg::disc_result_t r;
        apx = $signed(p.a_pos_x); apy = $signed(p.a_pos_y);
        avx = $signed(p.a_vel_x); avy = $signed(p.a_vel_y);
        bpx = $signed(p.b_pos_x); bpy = $signed(p.b_pos_y);
        bvx = $signed(p.b_vel_x); bvy = $signed(p.b_vel_y);
        dd[0] = apx - bpx;
        dd[1] = apy - bpy;
        dx = 128'(dd[0]);
        dy = 128'(dd[1]);
        d2 = dx * dx + dy * dy;
        rsum = (64'(p.a_radius) + 64'(p.b_radius)) << F;
        r2 = 128'(rsum) * 128'(rsum);
        oc = dec_pkg::OUTCOME_PASS;
        sat = 1'b0;
        if (d2 < r2) begin
            if (d2 == 0) begin
                oc = dec_pkg::OUTCOME_PUSH;
                h = longint'(rsum >> 1);
                apx -= h; apy -= h;
                bpx += h; bpy += h;
            end else begin
                oc = dec_pkg::OUTCOME_BOUNCE;
                dvx = 128'(avx - bvx);
                dvy = 128'(avy - bvy);
                dot = dvx * dx + dvy * dy;
                adot = (dot < 0) ? -dot : dot;
                msum = 64'(p.a_mass) + 64'(p.b_mass);
                ra = 64'd0;
                rb = 64'd0;
                if (msum != 0) begin
                    ra = ((64'(p.a_mass) << 1) << F) / msum;
                    rb = ((64'(p.b_mass) << 1) << F) / msum;
                end
                for (int c = 0; c < 2; c++) begin
                    num = adot * 128'(dd[c] < 0 ? -dd[c] : dd[c]);
                    quo = num / d2;
                    t = quo[63:0];
                    tneg = (dot < 0) != (dd[c] < 0);
                    pa = rb * t;
                    pb = ra * t;
                    da = longint'(pa >> F);
                    db = longint'(pb >> F);
                    if (tneg) begin
                        da = -da;
                        db = -db;
                    end
                    if (c == 0) begin
                        avx -= da;
                        bvx += db;
                    end else begin
                        avy -= da;
                        bvy += db;
                    end
                end
            end
        end
        r.new_a_pos_x = sat32(apx, sat);
        r.new_a_pos_y = sat32(apy, sat);
        r.new_a_vel_x = sat32(avx, sat);
        r.new_a_vel_y = sat32(avy, sat);
        r.new_b_pos_x = sat32(bpx, sat);
        r.new_b_pos_y = sat32(bpy, sat);
        r.new_b_vel_x = sat32(bvx, sat);
        r.new_b_vel_y = sat32(bvy, sat);
        r.outcome     = oc;
        r.saturated   = sat;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // Result checker
    always @(posedge aclk) begin
        dec_pkg::disc_result_t e;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no pair outstanding");
                mismatches++;
            end else begin
                e = expected_results.pop_front();
                check_field("new_a_pos_x", e.new_a_pos_x, m_data.new_a_pos_x);
                check_field("new_a_pos_y", e.new_a_pos_y, m_data.new_a_pos_y);
                check_field("new_a_vel_x", e.new_a_vel_x, m_data.new_a_vel_x);
                check_field("new_a_vel_y", e.new_a_vel_y, m_data.new_a_vel_y);
                check_field("new_b_pos_x", e.new_b_pos_x, m_data.new_b_pos_x);
                check_field("new_b_pos_y", e.new_b_pos_y, m_data.new_b_pos_y);
                check_field("new_b_vel_x", e.new_b_vel_x, m_data.new_b_vel_x);
                check_field("new_b_vel_y", e.new_b_vel_y, m_data.new_b_vel_y);
                check_field("outcome", 32'(e.outcome), 32'(m_data.outcome));
                check_field("saturated", 32'(e.saturated), 32'(m_data.saturated));
            end
        end
    end

    // Receiver: hold-off on request, otherwise stall on the current pattern
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                if ($urandom_range(0, 99) == 0)
                    ready_mode = $urandom_range(0, 2);
                case (ready_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 9) < 8);
                    default: m_ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    initial begin
        wait (cycles > CYCLE_LIMIT);
        $display("disc_elastic_collision_test: FAIL");
        $finish;
    end

    task automatic send_pair(input dec_pkg::disc_pair_t p);
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        expected_results.insert(expected_results.size(), collide_pair(p));
    endtask

    task automatic pause_sender(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic wait_all_results();
        pause_sender(1);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_vel();
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, 31);
    endfunction

    function automatic logic [31:0] rand_mass();
        logic [31:0] m;
        m = $urandom >> $urandom_range(0, 31);
        return (m == 0) ? 32'd1 : m;
    endfunction

    // kind 0: overlapping pair, 1: coincident centres, 2: any bits
    function automatic dec_pkg::disc_pair_t rand_pair(input int kind);
        dec_pkg::disc_pair_t p;
        longint span, ox, oy;
        p.a_pos_x  = $urandom;
        p.a_pos_y  = $urandom;
        p.a_vel_x  = $urandom;
        p.a_vel_y  = $urandom;
        p.a_radius = 10'($urandom);
        p.a_mass   = $urandom;
        p.b_pos_x  = $urandom;
        p.b_pos_y  = $urandom;
        p.b_vel_x  = $urandom;
        p.b_vel_y  = $urandom;
        p.b_radius = 10'($urandom);
        p.b_mass   = $urandom;
        if (p.a_mass == 0) p.a_mass = 32'd1;
        if (p.b_mass == 0) p.b_mass = 32'd1;
        if (kind == 2) return p;
        if ($urandom_range(0, 3) != 0) begin
            p.a_radius = 10'($urandom_range(0, 40));
            p.b_radius = 10'($urandom_range(0, 40));
            p.a_pos_x  = $signed(p.a_pos_x) >>> $urandom_range(0, 8);
            p.a_pos_y  = $signed(p.a_pos_y) >>> $urandom_range(0, 8);
            p.a_vel_x  = rand_vel();
            p.a_vel_y  = rand_vel();
            p.b_vel_x  = rand_vel();
            p.b_vel_y  = rand_vel();
            p.a_mass   = rand_mass();
            p.b_mass   = rand_mass();
        end
        if (p.a_radius == 0 && p.b_radius == 0 && $urandom_range(0, 7) != 0)
            p.a_radius = 10'd1;
        span = (longint'(p.a_radius) + longint'(p.b_radius)) << F;
        // stay inside the square of half the summed radii: an overlap unless both radii are zero or the position wraps
        ox = (span == 0) ? 0 : longint'($urandom_range(0, 32'(span))) - span / 2;
        oy = (span == 0) ? 0 : longint'($urandom_range(0, 32'(span))) - span / 2;
        if (kind == 1) begin
            ox = 0;
            oy = 0;
        end
        p.b_pos_x = 32'($signed(p.a_pos_x) - ox);
        p.b_pos_y = 32'($signed(p.a_pos_y) - oy);
        return p;
    endfunction

    function automatic dec_pkg::disc_pair_t make_pair(input logic [31:0] apx, apy, avx, avy,
            input logic [9:0] ar, input logic [31:0] am,
            input logic [31:0] bpx, bpy, bvx, bvy,
            input logic [9:0] br, input logic [31:0] bm);
        dec_pkg::disc_pair_t p;
        p = '{apx, apy, avx, avy, ar, am, bpx, bpy, bvx, bvy, br, bm};
        return p;
    endfunction

    task automatic test_pass_through();
        send_pair(make_pair(0, 0, 32'h0001_0000, 0, 10'd1, 32'h1_0000,
                            32'h0010_0000, 0, 0, 0, 10'd1, 32'h1_0000));
        send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                            10'd1023, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h8000_0000, 10'd1023, 32'd1));
        // both radii zero: coincident but still no overlap
        send_pair(make_pair(5, 5, 7, 7, 10'd0, 1, 5, 5, 9, 9, 10'd0, 1));
        // exactly touching is not an overlap
        send_pair(make_pair(0, 0, 0, 0, 10'd1, 32'h1_0000, 32'h0002_0000, 0, 0, 0, 10'd1,
                            32'h1_0000));
        pause_sender($urandom_range(1, 5));
    endtask

    task automatic test_coincident();
        send_pair(make_pair(0, 0, 3, -3, 10'd1, 32'h1_0000, 0, 0, -5, 5, 10'd1,
                            32'h1_0000));
        send_pair(make_pair(32'h7FFF_0000, 32'h8000_0100, 0, 0, 10'd1023, 1,
                            32'h7FFF_0000, 32'h8000_0100, 0, 0, 10'd1023, 1));
        send_pair(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 10'd0, 5,
                            32'h8000_0000, 32'h7FFF_FFFF, 2, 2, 10'd3, 7));
        pause_sender($urandom_range(1, 5));
    endtask

    task automatic test_bounce();
        // head-on along x, equal masses: velocities swap
        send_pair(make_pair(0, 0, 32'h0001_0000, 0, 10'd1, 32'h1_0000,
                            32'h0001_0000, 0, 32'hFFFF_0000, 0, 10'd1, 32'h1_0000));
        // glancing along y with unequal masses
        send_pair(make_pair(0, 0, 32'h0000_8000, 32'h0002_0000, 10'd2, 32'h3_0000,
                            32'h0000_4000, 32'h0001_0000, 0, 32'hFFFE_0000, 10'd2,
                            32'h1_0000));
        // distance of one LSB on each axis
        send_pair(make_pair(0, 0, 32'h0100_0000, 32'hFF00_0000, 10'd1, 1, 1, 1, 0, 0,
                            10'd1, 32'hFFFF_FFFF));
        // moving apart, extreme masses
        send_pair(make_pair(0, 0, 32'hFFFF_0000, 0, 10'd3, 32'hFFFF_FFFF,
                            32'h0001_0000, 0, 32'h0001_0000, 0, 10'd3, 32'hFFFF_FFFF));
        pause_sender($urandom_range(1, 5));
    endtask

    task automatic test_saturation();
        send_pair(make_pair(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 10'd1023, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                            10'd1023, 32'hFFFF_FFFF));
        send_pair(make_pair(32'h0000_1000, 0, 32'h8000_0000, 32'h8000_0000, 10'd5, 1,
                            0, 32'h0000_1000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 10'd5,
                            32'hFFFF_FFFF));
        send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 0, 0, 10'd1023, 2,
                            32'h8000_0000, 32'h8000_0000, 0, 0, 10'd1023, 3));
        wait_all_results();
    endtask

    // Receiver holds off while pairs keep coming until the input stalls
    task automatic test_backpressure();
        hold_cycles = 300;
        repeat (120) send_pair(rand_pair(0));
        wait_all_results();
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic test_random_stream(input int n_items);
        int sent;
        int burst;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                case ($urandom_range(0, 19))
                    0, 1:    send_pair(rand_pair(1));
                    2, 3, 4: send_pair(rand_pair(2));
                    default: send_pair(rand_pair(0));
                endcase
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 12));
            if ($urandom_range(0, 59) == 0)
                wait_all_results();
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        mismatches  = 0;
        cycles      = 0;
        hold_cycles = 0;
        ready_mode  = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_pass_through();
        test_coincident();
        test_bounce();
        test_saturation();
        test_backpressure();
        test_random_stream(1270);

        wait_all_results();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("disc_elastic_collision_test: PASS");
        end else begin
            $display("disc_elastic_collision_test: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/dec_pkg.sv
rtl/core/dec_div.sv
rtl/core/dec_queue.sv
rtl/core/dec_front.sv
rtl/core/dec_back.sv
rtl/core/disc_elastic_collision.sv
rtl/core/dec_checker.sv
tb/sv/disc_elastic_collision_test.sv
